// ===== rtl/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  // Default number of entries the table holds.
  localparam int unsigned CAPACITY_DEF = 16;

  // Width of the key and value fields.
  localparam int unsigned DATA_W = 32;

  // Width of the count fields on the result channel.
  localparam int unsigned COUNT_W = 5;

  // Operation codes carried on the request channel.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COMPARE = 2'd1,
    S_EXECUTE = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the request beat
    logic compare;  // register the per-cell compare vectors
    logic insert;   // open a slot and write the new entry
    logic shift;    // remove one matching entry by shifting the tail down
    logic clear;    // empty the table
    logic post;     // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;      // operation in progress
    logic  full;      // table holds every entry it can
    logic  any_eq;    // at least one matching entry remains
    logic  out_free;  // result register can take a new beat
  } sts_t;

endpackage

// ===== rtl/skvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skvt_ctrl
// Controller: sequences one operation at a time through compare and
// execute steps and issues commands to the datapath.
// ----------------------------------------------------------------------------
module skvt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  skvt_pkg::sts_t sts,
  output skvt_pkg::cmd_t cmd
);

  skvt_pkg::state_t state;
  skvt_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skvt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != skvt_pkg::S_IDLE);
    case (state)
      skvt_pkg::S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = skvt_pkg::S_COMPARE;
        end
      end
      skvt_pkg::S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = skvt_pkg::S_EXECUTE;
      end
      skvt_pkg::S_EXECUTE: begin
        // A remove drops one matching entry per cycle until none is left.
        if (sts.mode == skvt_pkg::MODE_REMOVE && sts.any_eq) begin
          cmd.shift = 1'b1;
        end else if (sts.out_free) begin
          cmd.post   = 1'b1;
          cmd.insert = (sts.mode == skvt_pkg::MODE_INSERT) && !sts.full;
          cmd.clear  = (sts.mode == skvt_pkg::MODE_CLEAR);
          state_next = skvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = skvt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/skvt_datapath.sv =====
// ----------------------------------------------------------------------------
// skvt_datapath
// Datapath: a row of key/value cells with per-cell comparators, the
// occupancy counter and the result register.
// ----------------------------------------------------------------------------
module skvt_datapath #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  skvt_pkg::cmd_t                      cmd,
  output skvt_pkg::sts_t                      sts,
  input  logic [1:0]                          mode,
  input  logic signed [skvt_pkg::DATA_W-1:0]  entry_key,
  input  logic signed [skvt_pkg::DATA_W-1:0]  entry_value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [1:0]                          status,
  output logic signed [skvt_pkg::DATA_W-1:0]  found_value,
  output logic [skvt_pkg::COUNT_W-1:0]        removed_count,
  output logic [skvt_pkg::COUNT_W-1:0]        entry_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = skvt_pkg::DATA_W;
  localparam int unsigned KW = skvt_pkg::COUNT_W;

  // Captured request.
  skvt_pkg::mode_t       op_mode;
  logic signed [DW-1:0]  op_key;
  logic signed [DW-1:0]  op_value;

  // Cell storage, one key and value per cell.
  logic signed [DW-1:0]  keys [CAPACITY];
  logic signed [DW-1:0]  vals [CAPACITY];

  // Per-cell compare results: key at or below, strictly below, equal.
  logic [CAPACITY-1:0]   le_vec;
  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   first_eq;

  logic [CW-1:0]         occ;
  logic [CW-1:0]         gone;
  logic                  full;
  logic                  out_free;

  logic [1:0]            status_next;
  logic signed [DW-1:0]  found_next;
  logic [CW-1:0]         removed_next;
  logic [CW-1:0]         count_next;
  logic [CW+KW-1:0]      removed_wide;
  logic [CW+KW-1:0]      count_wide;

  assign full     = (occ == CW'(CAPACITY));
  assign out_free = !rsp_valid || !rsp_stall;

  assign sts.mode     = op_mode;
  assign sts.full     = full;
  assign sts.any_eq   = |eq_vec;
  assign sts.out_free = out_free;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= skvt_pkg::mode_t'(mode);
      op_key   <= entry_key;
      op_value <= entry_value;
    end
  end

  // Occupancy and removal counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      gone <= '0;
    end else begin
      if (cmd.load) begin
        gone <= '0;
      end else if (cmd.shift) begin
        gone <= gone + CW'(1);
      end
      if (cmd.clear) begin
        occ <= '0;
      end else if (cmd.insert) begin
        occ <= occ + CW'(1);
      end else if (cmd.shift) begin
        occ <= occ - CW'(1);
      end
    end
  end

  // Cell row: each cell compares its own key and moves by one place.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic cell_valid;
    logic from_new;
    logic signed [DW-1:0] up_key;
    logic signed [DW-1:0] up_val;
    logic signed [DW-1:0] dn_key;
    logic signed [DW-1:0] dn_val;
    logic dn_eq;

    assign cell_valid = (CW'(i) < occ);

    // Neighbor taps at the ends of the row.
    if (i == 0) begin : g_head
      assign from_new = 1'b1;
      assign up_key   = op_key;
      assign up_val   = op_value;
    end else begin : g_body
      assign from_new = le_vec[i-1];
      assign up_key   = keys[i-1];
      assign up_val   = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign dn_key = keys[i];
      assign dn_val = vals[i];
      assign dn_eq  = 1'b0;
    end else begin : g_next
      assign dn_key = keys[i+1];
      assign dn_val = vals[i+1];
      assign dn_eq  = eq_vec[i+1];
    end

    // Compare vectors; a remove shifts the equal flags with the entries.
    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        le_vec[i] <= cell_valid && (keys[i] <= op_key);
        lt_vec[i] <= cell_valid && (keys[i] <  op_key);
        eq_vec[i] <= cell_valid && (keys[i] == op_key);
      end else if (cmd.shift && !lt_vec[i]) begin
        eq_vec[i] <= dn_eq;
      end
    end

    // Entry movement: open a slot on insert, close one on remove.
    always_ff @(posedge clk) begin
      if (cmd.insert && !le_vec[i]) begin
        keys[i] <= from_new ? op_key   : up_key;
        vals[i] <= from_new ? op_value : up_val;
      end else if (cmd.shift && !lt_vec[i]) begin
        keys[i] <= dn_key;
        vals[i] <= dn_val;
      end
    end
  end

  // Matching entries are contiguous, so the first one has no match below it.
  assign first_eq = eq_vec & ~(eq_vec << 1);

  // Result selection.
  always_comb begin
    found_next   = '0;
    removed_next = '0;
    count_next   = occ;
    status_next  = skvt_pkg::STATUS_DONE;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_eq[i]) begin
        found_next = found_next | vals[i];
      end
    end
    case (op_mode)
      skvt_pkg::MODE_INSERT: begin
        found_next = '0;
        if (full) begin
          status_next = skvt_pkg::STATUS_FULL;
        end else begin
          count_next = occ + CW'(1);
        end
      end
      skvt_pkg::MODE_FIND: begin
        if (!(|eq_vec)) begin
          status_next = skvt_pkg::STATUS_NOT_FOUND;
        end
      end
      skvt_pkg::MODE_REMOVE: begin
        found_next   = '0;
        removed_next = gone;
        if (gone == '0) begin
          status_next = skvt_pkg::STATUS_NOT_FOUND;
        end
      end
      skvt_pkg::MODE_CLEAR: begin
        found_next   = '0;
        removed_next = occ;
        count_next   = '0;
      end
      default: begin
        found_next = '0;
      end
    endcase
  end

  // Counts are shown masked to the width of the result fields.
  assign removed_wide = {{KW{1'b0}}, removed_next};
  assign count_wide   = {{KW{1'b0}}, count_next};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.post) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      status        <= status_next;
      found_value   <= found_next;
      removed_count <= removed_wide[KW-1:0];
      entry_count   <= count_wide[KW-1:0];
    end
  end

endmodule

// ===== rtl/sorted_key_value_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Up to CAPACITY signed key/value entries kept in ascending key order,
// with insert, find, remove-all-with-key and clear operations.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall) carries one operation per
//   beat: mode, entry_key and entry_value. The response channel (rsp_valid,
//   rsp_stall) returns one beat per request: status, found_value,
//   removed_count and entry_count.
//   One request is in progress at a time. Insert, find and clear pass through
//   a capture step, a compare step in which every cell compares its key in
//   parallel, and an execute step that registers the response beat. Remove
//   also drops the matching entries in its execute step, as the cell row
//   drops one entry per cycle. A new request is taken in the cycle after
//   the response is registered. Reset empties the table at once; stored
//   entries need no clearing. When the receiver stalls, the response
//   register holds its beat and a new request may still be accepted; that
//   request waits in its execute step until the response register is free.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          mode,
  input  logic signed [skvt_pkg::DATA_W-1:0]  entry_key,
  input  logic signed [skvt_pkg::DATA_W-1:0]  entry_value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [1:0]                          status,
  output logic signed [skvt_pkg::DATA_W-1:0]  found_value,
  output logic [skvt_pkg::COUNT_W-1:0]        removed_count,
  output logic [skvt_pkg::COUNT_W-1:0]        entry_count
);

  skvt_pkg::cmd_t cmd;
  skvt_pkg::sts_t sts;

  // Operation sequencer.
  skvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cell row, counters and response register.
  skvt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .entry_key     (entry_key),
    .entry_value   (entry_value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .found_value   (found_value),
    .removed_count (removed_count),
    .entry_count   (entry_count)
  );

endmodule
